/* sv/las_point_record_field_extractor_top_defines.svh */
// Assertion macros shared by the point record field extractor.
`ifndef LAS_POINT_RECORD_FIELD_EXTRACTOR_TOP_DEFINES_SVH
`define LAS_POINT_RECORD_FIELD_EXTRACTOR_TOP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LPRFE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define LPRFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* sv/lprfe_pkg.sv */
// Types, constants and helper functions of the point record field extractor.
package lprfe_pkg;

    // Identifiers of the result fields.
    typedef enum logic [4:0] {
        FID_X, FID_Y, FID_Z, FID_INTENSITY, FID_RETURN_NUM, FID_NUM_RETURNS,
        FID_CLASS_FLAGS, FID_CHANNEL, FID_SCAN_DIR, FID_EDGE, FID_CLASS,
        FID_USER_DATA, FID_SCAN_ANGLE, FID_SOURCE_ID, FID_GPS_TIME, FID_RED,
        FID_GREEN, FID_BLUE, FID_NIR, FID_WAVE_INDEX, FID_WAVE_OFFSET,
        FID_WAVE_SIZE, FID_WAVE_LOC, FID_WAVE_XT, FID_WAVE_YT, FID_WAVE_ZT,
        FID_LAYER, FID_END
    } t_field_id;

    // Configuration register indexes.
    localparam logic REG_RECORD_FORMAT = 1'b0;
    localparam logic REG_RECORD_LENGTH = 1'b1;

    localparam int MAX_RESULTS = 4;
    localparam logic [3:0] MAX_FORMAT = 4'd10;

    // Base record size of each point format.
    localparam logic [6:0] BASE_SIZE [11] = '{
        7'd20, 7'd28, 7'd26, 7'd34, 7'd57, 7'd63, 7'd30, 7'd36, 7'd38, 7'd59, 7'd67
    };

    // Results caused by one input byte, plus the flags they all share.
    typedef struct packed {
        logic [2:0]             count;
        logic [3:0][4:0]        id;
        logic [3:0][63:0]       val;
        logic                   done;
        logic                   lerr;
    } t_group;

    // Core kind, presence flags and start offsets of the optional blocks for one format.
    typedef struct packed {
        logic       ext;
        logic       has_gps;
        logic       has_rgb;
        logic       has_nir;
        logic       has_wave;
        logic [7:0] gps_q;
        logic [7:0] rgb_q;
        logic [7:0] nir_q;
        logic [7:0] wave_q;
    } t_layout;

    // Derives the block layout of a (legal) format number.
    function automatic t_layout layout_of(logic [3:0] f);
        t_layout l;
        logic [7:0] q;
        l.ext      = (f > 4'd5);
        l.has_gps  = (f == 4'd1) || (f > 4'd2);
        l.has_rgb  = (f == 4'd2) || (f == 4'd3) || (f == 4'd5) || (f == 4'd7) ||
                     (f == 4'd8) || (f == 4'd10);
        l.has_nir  = (f == 4'd8) || (f == 4'd10);
        l.has_wave = (f == 4'd4) || (f == 4'd5) || (f == 4'd9) || (f == 4'd10);
        q = l.ext ? 8'd22 : 8'd20;
        l.gps_q = q;
        q = q + (l.has_gps ? 8'd8 : 8'd0);
        l.rgb_q = q;
        q = q + (l.has_rgb ? 8'd6 : 8'd0);
        l.nir_q = q;
        q = q + (l.has_nir ? 8'd2 : 8'd0);
        l.wave_q = q;
        return l;
    endfunction

    // Appends one result to a group; results past the fourth are dropped.
    function automatic t_group push(t_group g, logic [4:0] id, logic [63:0] v);
        t_group r;
        r = g;
        if (g.count < 3'(MAX_RESULTS)) begin
            r.id[g.count[1:0]]  = id;
            r.val[g.count[1:0]] = v;
            r.count             = g.count + 3'd1;
        end
        return r;
    endfunction

endpackage

/* sv/lprfe_decode.sv */
// Decoder that turns one record byte into its result group and next state.
module lprfe_decode (
    input  logic [3:0]          i_format,
    input  logic [15:0]         i_length,
    input  logic [15:0]         i_position,
    input  logic [63:0]         i_assembly,
    input  logic [7:0]          i_byte,
    output lprfe_pkg::t_group   o_group,
    output logic [63:0]         o_assembly_next,
    output logic [15:0]         o_position_next
);
    import lprfe_pkg::*;

    logic [3:0]  fmt;
    logic [16:0] len;
    logic [6:0]  base;
    logic        last;
    logic        lerr;
    logic [63:0] asm_n;
    logic [63:0] take1, take2, take4, take8;
    logic [15:0] pos;
    logic [7:0]  b;
    t_layout     lay;
    t_group      g;

    // True when the byte position equals a block start plus an offset.
    function automatic logic at(logic [15:0] p, logic [7:0] q, logic [7:0] k);
        return p == {8'd0, q + k};
    endfunction

    // Effective format, length and end-of-record detection.
    assign fmt  = (i_format <= MAX_FORMAT) ? i_format : 4'd0;
    assign len  = (i_length != 16'd0) ? {1'b0, i_length} : 17'h10000;
    assign base = BASE_SIZE[fmt];
    assign last = ({1'b0, i_position} + 17'd1) == len;
    assign lerr = len < {10'd0, base};
    assign lay  = layout_of(fmt);
    assign pos  = i_position;
    assign b    = i_byte;

    // The new byte enters the little-endian assembly register from the top.
    assign asm_n = {b, i_assembly[63:8]};
    assign take1 = {56'd0, asm_n[63:56]};
    assign take2 = {48'd0, asm_n[63:48]};
    assign take4 = {32'd0, asm_n[63:32]};
    assign take8 = asm_n;

    assign o_assembly_next = asm_n;
    assign o_position_next = last ? 16'd0 : pos + 16'd1;

    // Fields completed by this byte, collected in record order.
    always_comb begin
        g      = '0;
        g.done = last;
        g.lerr = lerr;

        // Coordinates and intensity are common to every format.
        if (pos == 16'd3)  g = push(g, FID_X, take4);
        else if (pos == 16'd7)  g = push(g, FID_Y, take4);
        else if (pos == 16'd11) g = push(g, FID_Z, take4);
        else if (pos == 16'd13) g = push(g, FID_INTENSITY, take2);

        if (lay.ext) begin
            // Extended core with separate return and flag bytes.
            if (pos == 16'd14) begin
                g = push(g, FID_RETURN_NUM, {60'd0, b[3:0]});
                g = push(g, FID_NUM_RETURNS, {60'd0, b[7:4]});
            end else if (pos == 16'd15) begin
                g = push(g, FID_CLASS_FLAGS, {60'd0, b[3:0]});
                g = push(g, FID_CHANNEL, {62'd0, b[5:4]});
                g = push(g, FID_SCAN_DIR, {63'd0, b[6]});
                g = push(g, FID_EDGE, {63'd0, b[7]});
            end else if (pos == 16'd16) begin
                g = push(g, FID_CLASS, {56'd0, b});
            end else if (pos == 16'd17) begin
                g = push(g, FID_USER_DATA, {56'd0, b});
            end else if (pos == 16'd19) begin
                g = push(g, FID_SCAN_ANGLE, {{48{asm_n[63]}}, asm_n[63:48]});
            end else if (pos == 16'd21) begin
                g = push(g, FID_SOURCE_ID, take2);
            end
        end else begin
            // Legacy core with one packed return byte.
            if (pos == 16'd14) begin
                g = push(g, FID_RETURN_NUM, {61'd0, b[2:0]});
                g = push(g, FID_NUM_RETURNS, {61'd0, b[5:3]});
                g = push(g, FID_SCAN_DIR, {63'd0, b[6]});
                g = push(g, FID_EDGE, {63'd0, b[7]});
            end else if (pos == 16'd15) begin
                g = push(g, FID_CLASS, {56'd0, b});
            end else if (pos == 16'd16) begin
                g = push(g, FID_SCAN_ANGLE, {{56{b[7]}}, b});
            end else if (pos == 16'd17) begin
                g = push(g, FID_USER_DATA, {56'd0, b});
            end else if (pos == 16'd19) begin
                g = push(g, FID_SOURCE_ID, take2);
            end
        end

        // GPS time block.
        if (lay.has_gps && at(pos, lay.gps_q, 8'd7)) g = push(g, FID_GPS_TIME, take8);

        // Color block.
        if (lay.has_rgb) begin
            if (at(pos, lay.rgb_q, 8'd1)) g = push(g, FID_RED, take2);
            else if (at(pos, lay.rgb_q, 8'd3)) g = push(g, FID_GREEN, take2);
            else if (at(pos, lay.rgb_q, 8'd5)) g = push(g, FID_BLUE, take2);
        end

        // Near infrared channel.
        if (lay.has_nir && at(pos, lay.nir_q, 8'd1)) g = push(g, FID_NIR, take2);

        // Wave packet block.
        if (lay.has_wave) begin
            if (at(pos, lay.wave_q, 8'd0)) g = push(g, FID_WAVE_INDEX, take1);
            else if (at(pos, lay.wave_q, 8'd8))  g = push(g, FID_WAVE_OFFSET, take8);
            else if (at(pos, lay.wave_q, 8'd12)) g = push(g, FID_WAVE_SIZE, take4);
            else if (at(pos, lay.wave_q, 8'd16)) g = push(g, FID_WAVE_LOC, take4);
            else if (at(pos, lay.wave_q, 8'd20)) g = push(g, FID_WAVE_XT, take4);
            else if (at(pos, lay.wave_q, 8'd24)) g = push(g, FID_WAVE_YT, take4);
            else if (at(pos, lay.wave_q, 8'd28)) g = push(g, FID_WAVE_ZT, take4);
        end

        // Layer word and end marker on the last byte of the record.
        if (last) begin
            if (len >= ({10'd0, base} + 17'd4)) g = push(g, FID_LAYER, take4);
            g = push(g, FID_END, {47'd0, len});
        end
    end

    assign o_group = g;

endmodule

/* sv/lprfe_outbuf.sv */
// Result register that holds one byte's result group and sends it out one by one.
module lprfe_outbuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  lprfe_pkg::t_group   i_group,
    input  logic                i_stall,
    output logic                o_ready,
    output logic                o_valid,
    output logic [4:0]          o_field_id,
    output logic [63:0]         o_field_value,
    output logic                o_last_of_item,
    output logic                o_record_done,
    output logic                o_length_error
);
    import lprfe_pkg::*;

    logic [2:0] r_rem, n_rem;
    logic [1:0] r_idx, n_idx;
    t_group     r_group;
    logic       fire;
    logic       take_new;

    // A transfer happens when a result is shown and not stalled.
    assign fire     = (r_rem != 3'd0) && !i_stall;
    assign take_new = i_load && (i_group.count != 3'd0);

    // A new group may enter when nothing is held or the last held result leaves this cycle.
    assign o_ready = (r_rem == 3'd0) || ((r_rem == 3'd1) && !i_stall);

    // Remaining count and read index.
    always_comb begin
        n_rem = r_rem;
        n_idx = r_idx;
        if (fire) begin
            n_rem = r_rem - 3'd1;
            n_idx = r_idx + 2'd1;
        end
        if (take_new) begin
            n_rem = i_group.count;
            n_idx = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= 3'd0;
            r_idx <= 2'd0;
        end else begin
            r_rem <= n_rem;
            r_idx <= n_idx;
        end
    end

    // Group payload, loaded with every non-empty group.
    always_ff @(posedge i_clk) begin
        if (take_new) begin
            r_group <= i_group;
        end
    end

    assign o_valid        = (r_rem != 3'd0);
    assign o_field_id     = r_group.id[r_idx];
    assign o_field_value  = r_group.val[r_idx];
    assign o_last_of_item = (r_rem == 3'd1);
    assign o_record_done  = r_group.done;
    assign o_length_error = r_group.lerr;

endmodule

/* sv/las_point_record_field_extractor_top.sv */
// Top level of the point record field extractor for point formats 0 to 10.
//
// Usage: record bytes enter on the input channel (i_valid, o_stall,
// i_record_byte), one transfer per byte, in record order. Each byte yields
// zero to four results on the output channel (o_valid, i_stall and the
// field ports); a result transfer moves one (field id, value) pair.
// Format and record length are written through i_wr_en, i_wr_index and
// i_wr_data while the block is idle.
// Latency: results of a byte appear in the cycle after its transfer.
// Throughput: one byte per cycle while each byte yields at most one result
// and the receiver does not stall; a byte with several results holds the input
// until the single result register, which drains one result per unstalled cycle, is down to its last one.
// Reset sets format 0, length 20 and the byte position to the record start.
// When the receiver stalls, the shown result holds and input is stalled
// once the held group cannot finish in the current cycle.
module las_point_record_field_extractor_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_en,
    input  logic        i_wr_index,
    input  logic [15:0] i_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_record_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_field_id,
    output logic [63:0] o_field_value,
    output logic        o_last_of_item,
    output logic        o_record_done,
    output logic        o_length_error
);
    import lprfe_pkg::*;
    `include "las_point_record_field_extractor_top_defines.svh"

    logic [3:0]  r_format;
    logic [15:0] r_length;
    logic [15:0] r_position;
    logic [63:0] r_assembly;
    logic [63:0] asm_next;
    logic [15:0] pos_next;
    logic        ready;
    logic        accept;
    t_group      group;

    assign o_stall = !ready;
    assign accept  = i_valid && ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= 4'd0;
            r_length <= 16'd20;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                REG_RECORD_FORMAT: r_format <= i_wr_data[3:0];
                REG_RECORD_LENGTH: r_length <= i_wr_data;
                default:           r_length <= r_length;
            endcase
        end
    end

    // Byte position and assembly register advance with each input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= 16'd0;
            r_assembly <= 64'd0;
        end else if (accept) begin
            r_position <= pos_next;
            r_assembly <= asm_next;
        end
    end

    lprfe_decode u_decode (
        .i_format        (r_format),
        .i_length        (r_length),
        .i_position      (r_position),
        .i_assembly      (r_assembly),
        .i_byte          (i_record_byte),
        .o_group         (group),
        .o_assembly_next (asm_next),
        .o_position_next (pos_next)
    );

    lprfe_outbuf u_outbuf (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (accept),
        .i_group        (group),
        .i_stall        (i_stall),
        .o_ready        (ready),
        .o_valid        (o_valid),
        .o_field_id     (o_field_id),
        .o_field_value  (o_field_value),
        .o_last_of_item (o_last_of_item),
        .o_record_done  (o_record_done),
        .o_length_error (o_length_error)
    );

    // A byte is taken only while the held group finishes in the same cycle.
    `LPRFE_ASSERT_SAME(a_accept_when_drained, i_valid && !o_stall && o_valid, o_last_of_item && !i_stall, "input taken while results still pending")
    // The end marker closes both the byte's group and the record.
    `LPRFE_ASSERT_SAME(a_end_is_last, o_valid && (o_field_id == FID_END), o_last_of_item && o_record_done, "end result not last of record byte")
    // A held result stays while the receiver stalls.
    `LPRFE_ASSERT_NEXT(a_hold_on_stall, o_valid && i_stall, o_valid && $stable(o_field_id) && $stable(o_field_value), "stalled result changed")

endmodule

/* test/lprfe_field_checker.sv */
// Scoreboard for the point record field extractor: predicts each field result and compares it.
module lprfe_field_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_en,
    input  logic        i_wr_index,
    input  logic [15:0] i_wr_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_record_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [4:0]  i_field_id,
    input  logic [63:0] i_field_value,
    input  logic        i_last_of_item,
    input  logic        i_record_done,
    input  logic        i_length_error,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import lprfe_pkg::*;

    // One expected result transfer.
    typedef struct packed {
        logic [4:0]  id;
        logic [63:0] value;
        logic        last_of_item;
        logic        record_done;
        logic        length_error;
    } t_expected_field;

    // Fixed part of the record for each point format.
    localparam int FORMAT_BASE_BYTES [11] = '{20, 28, 26, 34, 57, 63, 30, 36, 38, 59, 67};

    // Shadow of the block's registers and decode state.
    logic [3:0]      cur_format;
    logic [15:0]     cur_length;
    logic [15:0]     byte_pos;
    logic [63:0]     shift_reg;

    // Results caused by the byte being decoded.
    logic [4:0]      grp_id [4];
    logic [63:0]     grp_val [4];
    int              grp_n;

    t_expected_field pending_fields [$];
    t_expected_field head;
    t_field_id       exp_id;
    int              mismatches;
    int              results_checked;

    // Value of the last n bytes held in the shift register.
    function automatic logic [63:0] last_bytes(int n);
        return shift_reg >> (64 - 8 * n);
    endfunction

    // Adds a result to the current group; a byte yields at most four.
    function automatic void add_field(t_field_id id, logic [63:0] v);
        if (grp_n < 4) begin
            grp_id[grp_n]  = id;
            grp_val[grp_n] = v;
            grp_n++;
        end
    endfunction

    // Decodes one accepted record byte and queues the results it causes.
    task automatic predict_fields(input logic [7:0] b);
        int  f;
        int  len;
        int  base;
        int  p;
        int  q;
        bit  last;
        bit  lerr;
        t_expected_field r;

        f    = (cur_format <= 4'd10) ? int'(cur_format) : 0;
        len  = (cur_length != 16'd0) ? int'(cur_length) : 65536;
        base = FORMAT_BASE_BYTES[f];
        p    = int'(byte_pos);
        last = (p + 1 == len);
        lerr = (len < base);
        shift_reg = {b, shift_reg[63:8]};
        grp_n = 0;

        // Coordinates and intensity are common to every format.
        if (p == 3) add_field(FID_X, last_bytes(4));
        else if (p == 7) add_field(FID_Y, last_bytes(4));
        else if (p == 11) add_field(FID_Z, last_bytes(4));
        else if (p == 13) add_field(FID_INTENSITY, last_bytes(2));

        // The core differs between the legacy and the extended formats.
        if (f > 5) begin
            case (p)
                14: begin
                    add_field(FID_RETURN_NUM, 64'(b[3:0]));
                    add_field(FID_NUM_RETURNS, 64'(b[7:4]));
                end
                15: begin
                    add_field(FID_CLASS_FLAGS, 64'(b[3:0]));
                    add_field(FID_CHANNEL, 64'(b[5:4]));
                    add_field(FID_SCAN_DIR, 64'(b[6]));
                    add_field(FID_EDGE, 64'(b[7]));
                end
                16: add_field(FID_CLASS, 64'(b));
                17: add_field(FID_USER_DATA, 64'(b));
                19: add_field(FID_SCAN_ANGLE, {{48{shift_reg[63]}}, shift_reg[63:48]});
                21: add_field(FID_SOURCE_ID, last_bytes(2));
                default: ;
            endcase
            q = 22;
        end else begin
            case (p)
                14: begin
                    add_field(FID_RETURN_NUM, 64'(b[2:0]));
                    add_field(FID_NUM_RETURNS, 64'(b[5:3]));
                    add_field(FID_SCAN_DIR, 64'(b[6]));
                    add_field(FID_EDGE, 64'(b[7]));
                end
                15: add_field(FID_CLASS, 64'(b));
                16: add_field(FID_SCAN_ANGLE, {{56{b[7]}}, b});
                17: add_field(FID_USER_DATA, 64'(b));
                19: add_field(FID_SOURCE_ID, last_bytes(2));
                default: ;
            endcase
            q = 20;
        end

        // Optional blocks follow the core in a fixed order.
        if (f == 1 || f > 2) begin
            if (p == q + 7) add_field(FID_GPS_TIME, last_bytes(8));
            q += 8;
        end
        if (f inside {2, 3, 5, 7, 8, 10}) begin
            if (p == q + 1) add_field(FID_RED, last_bytes(2));
            else if (p == q + 3) add_field(FID_GREEN, last_bytes(2));
            else if (p == q + 5) add_field(FID_BLUE, last_bytes(2));
            q += 6;
        end
        if (f == 8 || f == 10) begin
            if (p == q + 1) add_field(FID_NIR, last_bytes(2));
            q += 2;
        end
        if (f inside {4, 5, 9, 10}) begin
            if (p == q) add_field(FID_WAVE_INDEX, last_bytes(1));
            else if (p == q + 8) add_field(FID_WAVE_OFFSET, last_bytes(8));
            else if (p == q + 12) add_field(FID_WAVE_SIZE, last_bytes(4));
            else if (p == q + 16) add_field(FID_WAVE_LOC, last_bytes(4));
            else if (p == q + 20) add_field(FID_WAVE_XT, last_bytes(4));
            else if (p == q + 24) add_field(FID_WAVE_YT, last_bytes(4));
            else if (p == q + 28) add_field(FID_WAVE_ZT, last_bytes(4));
        end

        // The record's last byte adds the layer word and the end marker.
        if (last) begin
            if (len >= base + 4) add_field(FID_LAYER, last_bytes(4));
            add_field(FID_END, 64'(len));
        end

        for (int k = 0; k < grp_n; k++) begin
            r.id           = grp_id[k];
            r.value        = grp_val[k];
            r.last_of_item = (k == grp_n - 1);
            r.record_done  = last;
            r.length_error = lerr;
            pending_fields.push_back(r);
        end

        byte_pos = last ? 16'd0 : 16'(p + 1);
    endtask

    // Result transfers are checked before the byte accepted at the same edge is queued.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_format = 4'd0;
            cur_length = 16'd20;
            byte_pos   = 16'd0;
            shift_reg  = 64'd0;
            pending_fields.delete();
            mismatches      = 0;
            results_checked = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                results_checked++;
                if (pending_fields.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result id %0d value %h",
                                 $realtime, i_field_id, i_field_value);
                    mismatches++;
                end else begin
                    head = pending_fields.pop_front();
                    if (i_field_id !== head.id || i_field_value !== head.value ||
                        i_last_of_item !== head.last_of_item ||
                        i_record_done !== head.record_done ||
                        i_length_error !== head.length_error) begin
                        if (mismatches < 10) begin
                            exp_id = t_field_id'(head.id);
                            $display("%0t: expected %s %h last %b done %b lerr %b,",
                                     $realtime, exp_id.name(), head.value,
                                     head.last_of_item, head.record_done,
                                     head.length_error);
                            $display("    got id %0d %h last %b done %b lerr %b",
                                     i_field_id, i_field_value,
                                     i_last_of_item, i_record_done, i_length_error);
                        end
                        mismatches++;
                    end
                end
            end
            if (i_wr_en) begin
                if (i_wr_index == REG_RECORD_FORMAT) cur_format = i_wr_data[3:0];
                else cur_length = i_wr_data;
            end
            if (i_in_valid && !i_in_stall) predict_fields(i_record_byte);
        end
        o_mismatches      <= mismatches;
        o_pending         <= pending_fields.size();
        o_results_checked <= results_checked;
    end

endmodule

/* test/tb_las_point_record_field_extractor_top.sv */
// Testbench top for the point record field extractor: clock, reset, stimulus and verdict.
module tb_las_point_record_field_extractor_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lprfe_pkg::*;

    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int RANDOM_BYTES  = 220;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_wr_en = 1'b0;
    logic        i_wr_index = 1'b0;
    logic [15:0] i_wr_data = 16'd0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_record_byte = 8'd0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [4:0]  o_field_id;
    logic [63:0] o_field_value;
    logic        o_last_of_item;
    logic        o_record_done;
    logic        o_length_error;

    int mismatches;
    int pending;
    int results_checked;
    int idle_rate = 0;
    int bytes_sent = 0;
    int settings_written = 0;

    las_point_record_field_extractor_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr_en        (i_wr_en),
        .i_wr_index     (i_wr_index),
        .i_wr_data      (i_wr_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_record_byte  (i_record_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_field_id     (o_field_id),
        .o_field_value  (o_field_value),
        .o_last_of_item (o_last_of_item),
        .o_record_done  (o_record_done),
        .o_length_error (o_length_error)
    );

    lprfe_field_checker u_field_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_wr_en           (i_wr_en),
        .i_wr_index        (i_wr_index),
        .i_wr_data         (i_wr_data),
        .i_in_valid        (i_valid),
        .i_in_stall        (o_stall),
        .i_record_byte     (i_record_byte),
        .i_out_valid       (o_valid),
        .i_out_stall       (i_stall),
        .i_field_id        (o_field_id),
        .i_field_value     (o_field_value),
        .i_last_of_item    (o_last_of_item),
        .i_record_done     (o_record_done),
        .i_length_error    (o_length_error),
        .o_mismatches      (mismatches),
        .o_pending         (pending),
        .o_results_checked (results_checked)
    );

    // Free-running clock.
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Receiver backpressure comes in random bursts while idling is enabled.
    initial begin
        forever begin
            @(posedge i_clk);
            if (idle_rate > 0 && $urandom_range(0, 99) < idle_rate) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog for a hung handshake.
    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("** las_point_record_field_extractor_top: FAILED **");
        $finish;
    end

    // Byte values weighted toward the sign and all-ones boundaries.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offers one byte and waits for its transfer; valid stays high afterward.
    task automatic send_byte(input logic [7:0] b);
        if (idle_rate > 0 && $urandom_range(0, 99) < idle_rate) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_record_byte <= b;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        bytes_sent++;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_byte(pick_byte());
    endtask

    // Waits until every result has drained, then writes both registers.
    task automatic set_config(input int fmt, input int len);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_wr_en    <= 1'b1;
        i_wr_index <= REG_RECORD_FORMAT;
        i_wr_data  <= 16'(fmt);
        @(posedge i_clk);
        i_wr_index <= REG_RECORD_LENGTH;
        i_wr_data  <= 16'(len);
        @(posedge i_clk);
        i_wr_en <= 1'b0;
        settings_written++;
    endtask

    // Record length that lands below, at or past the fixed part of the format.
    function automatic int pick_length(input int fmt);
        int base;
        base = (fmt <= 10) ? int'(BASE_SIZE[fmt]) : 20;
        case ($urandom_range(0, 9))
            0: return $urandom_range(1, base - 1);
            1: return base;
            2: return base + $urandom_range(1, 3);
            default: return base + $urandom_range(4, 12);
        endcase
    endfunction

    initial begin
        int fmt;
        int len;
        int k;
        int new_len;
        int random_start;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset layout with all-ones bytes, then short records whose
        // last byte already carries four fields, one of them an unknown format.
        send_random(0);
        repeat (20) send_byte(8'hFF);
        set_config(6, 16);
        for (int i = 0; i < 16; i++) send_byte((i % 2 == 0) ? 8'h00 : 8'hFF);
        set_config(13, 15);
        repeat (15) send_byte(8'h80);

        // Random records over every format, with occasional register changes mid-record.
        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            fmt = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 15) : $urandom_range(0, 10);
            len = pick_length(fmt);
            case ($urandom_range(0, 3))
                0: idle_rate = 0;
                1: idle_rate = 4;
                2: idle_rate = 15;
                default: idle_rate = 40;
            endcase
            set_config(fmt, len);
            if (len >= 3 && $urandom_range(0, 5) == 0) begin
                k = $urandom_range(1, len - 1);
                send_random(k);
                new_len = $urandom_range(k + 1, k + 24);
                set_config($urandom_range(0, 10), new_len);
                send_random(new_len - k);
            end else begin
                send_random(len);
            end
        end

        // Closing records with no idling at all.
        idle_rate = 0;
        set_config(5, 71);
        send_random(71);
        set_config(10, 75);
        send_random(75);

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d record bytes under %0d register settings (formats 0-15,",
                 bytes_sent, settings_written);
        $display("short, exact and padded lengths, mid-record changes); %0d results checked.",
                 results_checked);
        if (mismatches == 0 && pending == 0) begin
            $display("** las_point_record_field_extractor_top: PASSED **");
        end else begin
            $display("** las_point_record_field_extractor_top: FAILED **");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/lprfe_pkg.sv
sv/lprfe_decode.sv
sv/lprfe_outbuf.sv
sv/las_point_record_field_extractor_top.sv
test/lprfe_field_checker.sv
test/tb_las_point_record_field_extractor_top.sv
